// ----- sv/key_edge_state_table_defines.svh -----
// Assertion macros for the key edge state table.
// Expects clk and rst in the scope of each use; no other dependencies.
`ifndef KEY_EDGE_STATE_TABLE_DEFINES_SVH
`define KEY_EDGE_STATE_TABLE_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define KEST_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("key table check failed");

// Condition holds in the cycle after the trigger.
`define KEST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("key table check failed");

`endif

// ----- sv/kest_pkg.sv -----
// Shared constants and types for the key edge state table.
// Used by kest_cell and key_edge_state_table; no dependencies.
package kest_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int KEY_W         = 25;
  localparam int CMD_W         = 3;
  localparam int PH_W          = 2;
  localparam int OUT_CNT_W     = 5;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int CNT_X_W       = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

  localparam logic [CMD_W-1:0] CMD_PRESS   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [PH_W-1:0] PH_ABSENT = 2'd0;
  localparam logic [PH_W-1:0] PH_TRIG   = 2'd1;
  localparam logic [PH_W-1:0] PH_PRES   = 2'd2;
  localparam logic [PH_W-1:0] PH_REL    = 2'd3;

  // Command token walking the row of cells.
  typedef struct packed {
    logic             active;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic             found;
    logic [PH_W-1:0]  state;
    logic             free_seen;
    logic [CNT_W-1:0] cnt;
  } tok_t;

  // Insert broadcast issued when a press of a new key completes.
  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] key;
  } ins_t;

endpackage

// ----- sv/kest_cell.sv -----
// One table slot: valid mark, key and phase, updated as the token passes.
// Depends on kest_pkg.
module kest_cell (
  input  logic          clk,
  input  logic          rst,
  input  kest_pkg::tok_t tok_in,
  input  kest_pkg::ins_t ins,
  output kest_pkg::tok_t tok_out,
  output logic          cand
);

  logic                      valid;
  logic [kest_pkg::KEY_W-1:0] key;
  logic [kest_pkg::PH_W-1:0]  phase;

  logic                      valid_next;
  logic [kest_pkg::PH_W-1:0]  phase_next;
  logic                      cand_next;
  kest_pkg::tok_t            tok_next;
  logic                      match;
  logic                      cnt_inc;
  logic                      commit;

  assign match  = valid && (key == tok_in.key);
  assign commit = ins.en && cand;

  always_comb begin
    tok_next   = tok_in;
    valid_next = valid;
    phase_next = phase;
    cand_next  = cand;
    cnt_inc    = valid;
    if (tok_in.active) begin
      cand_next = 1'b0;
      case (tok_in.cmd)
        kest_pkg::CMD_PRESS: begin
          if (match) begin
            tok_next.found = 1'b1;
            tok_next.state = phase;
          end
          if (!valid && !tok_in.free_seen) begin
            cand_next          = 1'b1;
            tok_next.free_seen = 1'b1;
          end
        end
        kest_pkg::CMD_RELEASE: begin
          if (match) begin
            phase_next     = kest_pkg::PH_REL;
            tok_next.found = 1'b1;
            tok_next.state = kest_pkg::PH_REL;
          end
        end
        kest_pkg::CMD_TICK: begin
          if (valid && phase == kest_pkg::PH_TRIG) begin
            phase_next = kest_pkg::PH_PRES;
          end
          if (valid && phase == kest_pkg::PH_REL) begin
            valid_next = 1'b0;
            cnt_inc    = 1'b0;
          end
        end
        kest_pkg::CMD_QUERY: begin
          if (match) begin
            tok_next.found = 1'b1;
            tok_next.state = phase;
          end
        end
        kest_pkg::CMD_CLEAR: begin
          valid_next = 1'b0;
          cnt_inc    = 1'b0;
        end
        default: begin
        end
      endcase
      tok_next.cnt = tok_in.cnt + kest_pkg::CNT_W'(cnt_inc);
    end
    if (commit) begin
      valid_next = 1'b1;
      phase_next = kest_pkg::PH_TRIG;
    end
  end

  always_ff @(posedge clk) begin
    phase             <= phase_next;
    tok_out.cmd       <= tok_next.cmd;
    tok_out.key       <= tok_next.key;
    tok_out.found     <= tok_next.found;
    tok_out.state     <= tok_next.state;
    tok_out.free_seen <= tok_next.free_seen;
    tok_out.cnt       <= tok_next.cnt;
    if (commit) begin
      key <= ins.key;
    end
    if (rst) begin
      valid          <= 1'b0;
      cand           <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      valid          <= valid_next;
      cand           <= cand_next;
      tok_out.active <= tok_in.active;
    end
  end

endmodule

// ----- sv/key_edge_state_table.sv -----
// Key edge state table: a command token walks a row of TABLE_ENTRIES slot
// cells, one cell per cycle, and the result is registered at the tail of the
// row; the table takes one command at a time, so a new beat is accepted only
// after the result of the last one has been handed to the output.
// Synchronous reset clears every valid mark at once; no clearing pass.
// Depends on kest_pkg, kest_cell and key_edge_state_table_defines.svh.
`include "key_edge_state_table_defines.svh"

module key_edge_state_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kest_pkg::CMD_W-1:0]     cmd,
  input  logic [kest_pkg::KEY_W-1:0]     key_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kest_pkg::PH_W-1:0]      key_state,
  output logic [kest_pkg::OUT_CNT_W-1:0] entry_count,
  output logic                          press_dropped
);

  kest_pkg::tok_t                   chain [kest_pkg::TABLE_ENTRIES+1];
  logic [kest_pkg::TABLE_ENTRIES-1:0] cand;
  kest_pkg::ins_t                   ins;

  kest_pkg::tok_t head;
  logic           busy;
  logic           done_valid;
  kest_pkg::tok_t done_tok;
  logic           finish;
  logic           is_press;
  logic           dropped;
  logic [kest_pkg::PH_W-1:0]    state_res;
  logic [kest_pkg::CNT_X_W-1:0] cnt_res;

  assign chain[0] = head;
  assign in_ready = !busy;
  assign finish   = done_valid && (!out_valid || out_ready);
  assign is_press = (done_tok.cmd == kest_pkg::CMD_PRESS);
  assign ins.en   = finish && is_press && !done_tok.found && done_tok.free_seen;
  assign ins.key  = done_tok.key;
  assign dropped  = is_press && !done_tok.found && !done_tok.free_seen;
  assign cnt_res  = kest_pkg::CNT_X_W'(done_tok.cnt) + kest_pkg::CNT_X_W'(ins.en);

  always_comb begin
    state_res = kest_pkg::PH_ABSENT;
    if (done_tok.found) begin
      state_res = done_tok.state;
    end else if (is_press && done_tok.free_seen) begin
      state_res = kest_pkg::PH_TRIG;
    end
  end

  for (genvar i = 0; i < kest_pkg::TABLE_ENTRIES; i++) begin : g_cell
    kest_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[i]),
      .ins     (ins),
      .tok_out (chain[i+1]),
      .cand    (cand[i])
    );
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      head.cmd       <= cmd;
      head.key       <= key_code;
      head.found     <= 1'b0;
      head.state     <= kest_pkg::PH_ABSENT;
      head.free_seen <= 1'b0;
      head.cnt       <= '0;
    end
    if (chain[kest_pkg::TABLE_ENTRIES].active) begin
      done_tok <= chain[kest_pkg::TABLE_ENTRIES];
    end
    if (finish) begin
      key_state     <= state_res;
      entry_count   <= cnt_res[kest_pkg::OUT_CNT_W-1:0];
      press_dropped <= dropped;
    end
    if (rst) begin
      busy        <= 1'b0;
      done_valid  <= 1'b0;
      out_valid   <= 1'b0;
      head.active <= 1'b0;
    end else begin
      head.active <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (chain[kest_pkg::TABLE_ENTRIES].active) begin
        done_valid <= 1'b1;
      end else if (finish) begin
        done_valid <= 1'b0;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `KEST_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, busy)
  `KEST_ASSERT_SAME(a_tail_busy, chain[kest_pkg::TABLE_ENTRIES].active, busy && !done_valid)
  `KEST_ASSERT_SAME(a_one_cand, 1'b1, $onehot0(cand))
  `KEST_ASSERT_SAME(a_insert_cand, ins.en, $onehot(cand))

endmodule

// ----- dv/tb_key_edge_state_table.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for key_edge_state_table: directed table, then random command
// traffic; each result beat is checked against its planned result or against a behavioural
// key table kept in the testbench. Depends on kest_pkg and the key_edge_state_table RTL.
module tb_key_edge_state_table;

  localparam logic [kest_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [kest_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [kest_pkg::CMD_W-1:0] CMD_SPARE_C = 3'd7;
  localparam int RANDOM_BEATS  = 1000;
  localparam int KEY_POOL      = 20;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 2 * (kest_pkg::TABLE_ENTRIES + 3);

  typedef struct {
    logic [kest_pkg::PH_W-1:0]      state;
    logic [kest_pkg::OUT_CNT_W-1:0] count;
    logic                           dropped;
  } key_result_t;

  typedef struct {
    logic [kest_pkg::CMD_W-1:0] op;
    logic [kest_pkg::KEY_W-1:0] code;
    bit                         typed;
    key_result_t                want;
  } plan_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [kest_pkg::CMD_W-1:0]     cmd = '0;
  logic [kest_pkg::KEY_W-1:0]     key_code = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [kest_pkg::PH_W-1:0]      key_state;
  logic [kest_pkg::OUT_CNT_W-1:0] entry_count;
  logic                           press_dropped;

  bit                         slot_used [kest_pkg::TABLE_ENTRIES];
  logic [kest_pkg::KEY_W-1:0] slot_code [kest_pkg::TABLE_ENTRIES];
  logic [kest_pkg::PH_W-1:0]  slot_ph   [kest_pkg::TABLE_ENTRIES];

  key_result_t                pending_results[$];
  plan_row_t                  directed_plan[$];
  logic [kest_pkg::KEY_W-1:0] key_pool[KEY_POOL];
  int                         fail_count = 0;
  int                         quiet_cycles = 0;
  bit                         steady = 1'b0;

  key_edge_state_table dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .key_code      (key_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .key_state     (key_state),
    .entry_count   (entry_count),
    .press_dropped (press_dropped)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic key_result_t apply_key_cmd(logic [kest_pkg::CMD_W-1:0] op,
                                                logic [kest_pkg::KEY_W-1:0] code);
    key_result_t r;
    int          hit;
    int          spare;
    int          n;
    r.state   = kest_pkg::PH_ABSENT;
    r.dropped = 1'b0;
    hit   = -1;
    spare = -1;
    n     = 0;
    for (int i = 0; i < kest_pkg::TABLE_ENTRIES; i++) begin
      if (hit < 0 && slot_used[i] && slot_code[i] == code) hit = i;
      if (spare < 0 && !slot_used[i]) spare = i;
    end
    case (op)
      kest_pkg::CMD_PRESS: begin
        if (hit >= 0) begin
          r.state = slot_ph[hit];
        end else if (spare >= 0) begin
          slot_used[spare] = 1'b1;
          slot_code[spare] = code;
          slot_ph[spare]   = kest_pkg::PH_TRIG;
          r.state          = kest_pkg::PH_TRIG;
        end else begin
          r.dropped = 1'b1;
        end
      end
      kest_pkg::CMD_RELEASE: begin
        if (hit >= 0) begin
          slot_ph[hit] = kest_pkg::PH_REL;
          r.state      = kest_pkg::PH_REL;
        end
      end
      kest_pkg::CMD_TICK: begin
        for (int i = 0; i < kest_pkg::TABLE_ENTRIES; i++) begin
          if (slot_used[i] && slot_ph[i] == kest_pkg::PH_TRIG) slot_ph[i] = kest_pkg::PH_PRES;
          else if (slot_used[i] && slot_ph[i] == kest_pkg::PH_REL) slot_used[i] = 1'b0;
        end
      end
      kest_pkg::CMD_QUERY: begin
        if (hit >= 0) r.state = slot_ph[hit];
      end
      kest_pkg::CMD_CLEAR: begin
        for (int i = 0; i < kest_pkg::TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
      end
      default: ;
    endcase
    for (int i = 0; i < kest_pkg::TABLE_ENTRIES; i++) if (slot_used[i]) n++;
    r.count = n[kest_pkg::OUT_CNT_W-1:0];
    return r;
  endfunction

  function automatic void add_row(logic [kest_pkg::CMD_W-1:0] op,
                                  logic [kest_pkg::KEY_W-1:0] code, bit typed,
                                  logic [kest_pkg::PH_W-1:0] st, int cnt, bit drop);
    plan_row_t row;
    row.op           = op;
    row.code         = code;
    row.typed        = typed;
    row.want.state   = st;
    row.want.count   = cnt[kest_pkg::OUT_CNT_W-1:0];
    row.want.dropped = drop;
    directed_plan.push_back(row);
  endfunction

  task automatic note_mismatch(string field, int got, int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  // Offer one command beat and hold it until taken; log the expected result on acceptance.
  task automatic drive_beat(logic [kest_pkg::CMD_W-1:0] op, logic [kest_pkg::KEY_W-1:0] code,
                            bit typed, key_result_t want);
    key_result_t predicted;
    if (!steady && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    key_code <= code;
    do @(posedge clk); while (!in_ready);
    predicted = apply_key_cmd(op, code);
    pending_results.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    key_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected beat, entry_count", int'(entry_count), 0);
      end else begin
        want = pending_results.pop_front();
        if (key_state !== want.state)
          note_mismatch("key_state", int'(key_state), int'(want.state));
        if (entry_count !== want.count)
          note_mismatch("entry_count", int'(entry_count), int'(want.count));
        if (press_dropped !== want.dropped)
          note_mismatch("press_dropped", int'(press_dropped), int'(want.dropped));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    key_result_t                none;
    logic [kest_pkg::CMD_W-1:0] op;
    logic [kest_pkg::KEY_W-1:0] code;
    int                         r;
    bit                         fill_mode;

    none.state   = kest_pkg::PH_ABSENT;
    none.count   = '0;
    none.dropped = 1'b0;
    for (int i = 0; i < kest_pkg::TABLE_ENTRIES; i++) slot_used[i] = 1'b0;

    //       op                     key_code     typed state                count drop
    add_row(kest_pkg::CMD_QUERY,   25'h0000000, 1'b1, kest_pkg::PH_ABSENT, 0,    1'b0);
    add_row(kest_pkg::CMD_PRESS,   25'h0000000, 1'b1, kest_pkg::PH_TRIG,   1,    1'b0);
    add_row(kest_pkg::CMD_PRESS,   25'h1FFFFFF, 1'b1, kest_pkg::PH_TRIG,   2,    1'b0);
    add_row(kest_pkg::CMD_PRESS,   25'h0000000, 1'b1, kest_pkg::PH_TRIG,   2,    1'b0);
    add_row(kest_pkg::CMD_RELEASE, 25'h1FFFFFF, 1'b1, kest_pkg::PH_REL,    2,    1'b0);
    add_row(kest_pkg::CMD_PRESS,   25'h1FFFFFF, 1'b1, kest_pkg::PH_REL,    2,    1'b0);
    add_row(kest_pkg::CMD_TICK,    25'h1555555, 1'b1, kest_pkg::PH_ABSENT, 1,    1'b0);
    add_row(kest_pkg::CMD_QUERY,   25'h0000000, 1'b1, kest_pkg::PH_PRES,   1,    1'b0);
    add_row(kest_pkg::CMD_PRESS,   25'h0000000, 1'b1, kest_pkg::PH_PRES,   1,    1'b0);
    add_row(kest_pkg::CMD_RELEASE, 25'h0AAAAAA, 1'b1, kest_pkg::PH_ABSENT, 1,    1'b0);
    add_row(CMD_SPARE_A,           25'h0000000, 1'b1, kest_pkg::PH_ABSENT, 1,    1'b0);
    add_row(CMD_SPARE_C,           25'h1FFFFFF, 1'b1, kest_pkg::PH_ABSENT, 1,    1'b0);
    add_row(kest_pkg::CMD_CLEAR,   25'h1FFFFFF, 1'b1, kest_pkg::PH_ABSENT, 0,    1'b0);
    for (int i = 0; i < kest_pkg::TABLE_ENTRIES; i++)
      add_row(kest_pkg::CMD_PRESS, (25'h1 << i) ^ 25'h0F0F0F0, 1'b0, kest_pkg::PH_ABSENT, 0,
              1'b0);
    add_row(kest_pkg::CMD_PRESS,   25'h1234567, 1'b1, kest_pkg::PH_ABSENT, 16,   1'b1);
    add_row(kest_pkg::CMD_RELEASE, 25'h0F0F0F1, 1'b0, kest_pkg::PH_ABSENT, 0,    1'b0);
    add_row(kest_pkg::CMD_TICK,    25'h0000000, 1'b0, kest_pkg::PH_ABSENT, 0,    1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i])
      drive_beat(directed_plan[i].op, directed_plan[i].code, directed_plan[i].typed,
                 directed_plan[i].want);

    foreach (key_pool[i]) key_pool[i] = kest_pkg::KEY_W'($urandom());
    fill_mode = 1'b0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      steady = (n >= 300 && n < 500);
      if (n % 50 == 0) fill_mode = ($urandom_range(1) != 0);
      if ($urandom_range(99) < 2)
        key_pool[$urandom_range(KEY_POOL - 1)] = kest_pkg::KEY_W'($urandom());
      code = key_pool[$urandom_range(KEY_POOL - 1)];
      r    = $urandom_range(99);
      if (fill_mode) begin
        if (r < 60)      op = kest_pkg::CMD_PRESS;
        else if (r < 70) op = kest_pkg::CMD_RELEASE;
        else if (r < 75) op = kest_pkg::CMD_TICK;
        else if (r < 95) op = kest_pkg::CMD_QUERY;
        else             op = kest_pkg::CMD_W'(CMD_SPARE_A + $urandom_range(2));
      end else begin
        if (r < 35)      op = kest_pkg::CMD_PRESS;
        else if (r < 58) op = kest_pkg::CMD_RELEASE;
        else if (r < 72) op = kest_pkg::CMD_TICK;
        else if (r < 90) op = kest_pkg::CMD_QUERY;
        else if (r < 92) op = kest_pkg::CMD_CLEAR;
        else if (r < 95) op = kest_pkg::CMD_W'(CMD_SPARE_A + $urandom_range(2));
        else begin
          op   = $urandom_range(1) ? kest_pkg::CMD_PRESS : kest_pkg::CMD_QUERY;
          code = kest_pkg::KEY_W'($urandom());
        end
      end
      drive_beat(op, code, 1'b0, none);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/kest_pkg.sv
sv/kest_cell.sv
sv/key_edge_state_table.sv
dv/tb_key_edge_state_table.sv
